[design/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define FSS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property at every clock edge, reset included.
`define FSS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[design/fss_pkg.sv]
// Types, constants and signature matching for the file signature sniffer.
package fss_pkg;

  localparam int unsigned CNT_W      = 13;
  localparam int unsigned WINDOW     = 4096;
  localparam int unsigned HEAD_DEPTH = 16;
  localparam int unsigned HEAD_IDX_W = 4;
  localparam int unsigned SHORT_LEN  = 12;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CLS_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_PERCENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_DIVISOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_MIN_LENGTH = 2'd2;

  localparam logic [PCT_W-1:0] TEXT_PERCENT_RST    = 7'd94;
  localparam logic [DIV_W-1:0] CONTROL_DIVISOR_RST = 8'd50;
  localparam logic [CFG_W-1:0] TEXT_MIN_LENGTH_RST = 13'd256;
  localparam logic [PCT_W-1:0] PERCENT_SCALE       = 7'd100;

  localparam logic [CLS_W-1:0] CLS_NONE    = 3'd0;
  localparam logic [CLS_W-1:0] CLS_AUDIO   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_IMAGE   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_ARCHIVE = 3'd3;
  localparam logic [CLS_W-1:0] CLS_DOC     = 3'd4;
  localparam logic [CLS_W-1:0] CLS_VIDEO   = 3'd5;
  localparam logic [CLS_W-1:0] CLS_TEXT    = 3'd6;
  localparam logic [CLS_W-1:0] CLS_INVALID = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } fss_in_t;

  typedef struct packed {
    logic             rejected;
    logic [CLS_W-1:0] match_class;
  } fss_out_t;

  typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

  typedef struct packed {
    head_t            head;
    logic [CNT_W-1:0] length;
    logic [CNT_W-1:0] printable;
    logic [CNT_W-1:0] control;
    logic             line_break;
  } fss_stats_t;

  typedef struct packed {
    logic [PCT_W-1:0] text_percent;
    logic [DIV_W-1:0] control_divisor;
    logic [CFG_W-1:0] text_min_length;
  } fss_cfg_t;

  // Compare n bytes (n <= 8) at offset off; pattern is right-aligned, first byte leftmost.
  function automatic logic head_match(head_t h, int unsigned off, int unsigned n,
                                      logic [63:0] pat);
    logic ok;
    ok = 1'b1;
    for (int unsigned i = 0; i < 8; i++) begin
      if (i < n) begin
        if (h[off + i] != pat[8 * (n - 1 - i) +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // First signature that matches gives the class. long16 permits the 16-byte header.
  function automatic logic [CLS_W-1:0] sig_class(head_t h, logic long16);
    logic [CLS_W-1:0] cls;
    logic             wave_ok;
    logic             form_ok;
    wave_ok = (head_match(h, 0, 4, 64'h52494646) || head_match(h, 0, 4, 64'h52463634))
              && head_match(h, 8, 4, 64'h57415645);
    form_ok = head_match(h, 0, 4, 64'h464F524D)
              && (head_match(h, 8, 4, 64'h41494646) || head_match(h, 8, 4, 64'h41494643));
    if (wave_ok || form_ok)                             cls = CLS_AUDIO;
    else if (head_match(h, 0, 4, 64'h4F676753))         cls = CLS_AUDIO;
    else if (head_match(h, 0, 4, 64'h664C6143))         cls = CLS_AUDIO;
    else if (head_match(h, 0, 3, 64'h494433))           cls = CLS_AUDIO;
    else if (head_match(h, 0, 8, 64'h89504E470D0A1A0A)) cls = CLS_IMAGE;
    else if (head_match(h, 0, 3, 64'hFFD8FF))           cls = CLS_IMAGE;
    else if (head_match(h, 0, 6, 64'h474946383761))     cls = CLS_IMAGE;
    else if (head_match(h, 0, 6, 64'h474946383961))     cls = CLS_IMAGE;
    else if (head_match(h, 0, 2, 64'h424D))             cls = CLS_IMAGE;
    else if (head_match(h, 0, 4, 64'h504B0304))         cls = CLS_ARCHIVE;
    else if (head_match(h, 0, 4, 64'h504B0506))         cls = CLS_ARCHIVE;
    else if (head_match(h, 0, 6, 64'h377ABCAF271C))     cls = CLS_ARCHIVE;
    else if (head_match(h, 0, 6, 64'h526172211A07))     cls = CLS_ARCHIVE;
    else if (head_match(h, 0, 2, 64'h1F8B))             cls = CLS_ARCHIVE;
    else if (head_match(h, 0, 3, 64'h425A68))           cls = CLS_ARCHIVE;
    else if (head_match(h, 0, 6, 64'hFD377A585A00))     cls = CLS_ARCHIVE;
    else if (head_match(h, 0, 5, 64'h255044462D))       cls = CLS_DOC;
    else if (head_match(h, 0, 4, 64'h7F454C46))         cls = CLS_DOC;
    else if (long16 && head_match(h, 0, 8, 64'h53514C6974652066)
             && head_match(h, 8, 8, 64'h6F726D6174203300)) cls = CLS_DOC;
    else if (head_match(h, 0, 2, 64'h4D5A))             cls = CLS_DOC;
    else if (head_match(h, 4, 4, 64'h66747970))         cls = CLS_VIDEO;
    else if (head_match(h, 0, 4, 64'h1A45DFA3))         cls = CLS_VIDEO;
    else                                                cls = CLS_NONE;
    return cls;
  endfunction

endpackage

[design/fss_accum.sv]
// Per-file byte accumulator: head bytes, length and byte-class counters.
module fss_accum #(
  parameter int unsigned Window = fss_pkg::WINDOW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  fss_pkg::fss_in_t    in_i,
  output fss_pkg::fss_stats_t stats_o
);
  import fss_pkg::*;

  localparam logic [CNT_W-1:0] WinLimit  = CNT_W'(Window);
  localparam logic [CNT_W-1:0] HeadLimit = CNT_W'(HEAD_DEPTH);

  head_t            head_q;
  logic [CNT_W-1:0] length_q, printable_q, control_q;
  logic             line_break_q;
  logic             in_win, is_print, is_break;
  logic [7:0]       c;

  assign c        = in_i.data_byte;
  assign in_win   = length_q < WinLimit;
  assign is_break = (c == 8'h0D) || (c == 8'h0A);
  assign is_print = is_break || (c == 8'h09) || ((c >= 8'h20) && (c <= 8'h7E));

  // State as it stands once this byte is counted.
  always_comb begin
    stats_o.head       = head_q;
    stats_o.length     = length_q;
    stats_o.printable  = printable_q;
    stats_o.control    = control_q;
    stats_o.line_break = line_break_q;
    if (in_win) begin
      if (length_q < HeadLimit) begin
        stats_o.head[length_q[HEAD_IDX_W-1:0]] = c;
      end
      if (is_print) begin
        stats_o.printable = printable_q + 1'b1;
      end else if (c != 8'h00) begin
        stats_o.control = control_q + 1'b1;
      end
      if (is_break) begin
        stats_o.line_break = 1'b1;
      end
      stats_o.length = length_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      head_q <= stats_o.head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q     <= '0;
      printable_q  <= '0;
      control_q    <= '0;
      line_break_q <= 1'b0;
    end else if (take_i) begin
      if (in_i.last) begin
        length_q     <= '0;
        printable_q  <= '0;
        control_q    <= '0;
        line_break_q <= 1'b0;
      end else begin
        length_q     <= stats_o.length;
        printable_q  <= stats_o.printable;
        control_q    <= stats_o.control;
        line_break_q <= stats_o.line_break;
      end
    end
  end

endmodule

[design/fss_classify.sv]
// Two-stage classifier: signature match and ratio products, then final decision.
module fss_classify (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                snap_valid_i,
  output logic                snap_ready_o,
  input  fss_pkg::fss_stats_t snap_i,
  input  fss_pkg::fss_cfg_t   cfg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fss_pkg::fss_out_t   out_o
);
  import fss_pkg::*;

  localparam int unsigned ProdW = CNT_W + PCT_W;
  localparam int unsigned CtW   = CNT_W + 1 + DIV_W;

  logic               b_vq, o_vq, b_en, o_en;
  logic               short_q, len_ok_q, line_break_q;
  logic [CLS_W-1:0]   sig_q;
  logic [ProdW-1:0]   pr_q, tp_q;
  logic [CtW-1:0]     ct_q;
  logic [CNT_W-1:0]   len_q;
  logic [CLS_W-1:0]   cls_d;
  logic               text_ok;
  fss_out_t           out_q;

  assign o_en         = !o_vq || out_ready_i;
  assign b_en         = !b_vq || o_en;
  assign snap_ready_o = b_en;

  always_ff @(posedge clk_i) begin
    if (b_en && snap_valid_i) begin
      short_q      <= snap_i.length < CNT_W'(SHORT_LEN);
      sig_q        <= sig_class(snap_i.head, snap_i.length >= CNT_W'(HEAD_DEPTH));
      pr_q         <= ProdW'(snap_i.printable) * ProdW'(PERCENT_SCALE);
      tp_q         <= ProdW'(cfg_i.text_percent) * ProdW'(snap_i.length);
      ct_q         <= (CtW'(snap_i.control) + 1'b1) * CtW'(cfg_i.control_divisor);
      len_ok_q     <= snap_i.length >= cfg_i.text_min_length;
      len_q        <= snap_i.length;
      line_break_q <= snap_i.line_break;
    end
  end

  assign text_ok = len_ok_q && (pr_q >= tp_q) && (ct_q <= CtW'(len_q)) && line_break_q;

  always_comb begin
    if (short_q)              cls_d = CLS_NONE;
    else if (sig_q != CLS_NONE) cls_d = sig_q;
    else if (text_ok)         cls_d = CLS_TEXT;
    else                      cls_d = CLS_NONE;
  end

  always_ff @(posedge clk_i) begin
    if (o_en && b_vq) begin
      out_q.rejected    <= cls_d != CLS_NONE;
      out_q.match_class <= cls_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vq <= 1'b0;
      o_vq <= 1'b0;
    end else begin
      if (b_en) begin
        b_vq <= snap_valid_i;
      end
      if (o_en) begin
        o_vq <= b_vq;
      end
    end
  end

  assign out_valid_o = o_vq;
  assign out_o       = out_q;

endmodule

[design/file_signature_sniffer.sv]
// A file's result passes from the snapshot register through the classifier's match
// and output registers to out_valid_o. Throughput: one byte per cycle;
// the input stalls only while all three stages behind the accumulator hold results
// that the output side has not taken. Reset clears the counters, the pipeline valids
// and the registers to 94/50/256; the head bytes are not cleared, only bytes written
// for the current file are read.
module file_signature_sniffer #(
  parameter int unsigned Window = fss_pkg::WINDOW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fss_pkg::fss_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fss_pkg::fss_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [fss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fss_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import fss_pkg::*;

  fss_cfg_t   cfg_q;
  fss_stats_t stats;
  fss_stats_t snap_q;
  logic       snap_vq, snap_ready, snap_en, take;

  // Configuration registers: plain writes, unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_percent    <= TEXT_PERCENT_RST;
      cfg_q.control_divisor <= CONTROL_DIVISOR_RST;
      cfg_q.text_min_length <= TEXT_MIN_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEXT_PERCENT:    cfg_q.text_percent    <= cfg_wdata_i[PCT_W-1:0];
        CFG_CONTROL_DIVISOR: cfg_q.control_divisor <= cfg_wdata_i[DIV_W-1:0];
        CFG_TEXT_MIN_LENGTH: cfg_q.text_min_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The snapshot slot frees up as soon as the classifier can take its content,
  // so bytes of the next file keep flowing while a result waits at the output.
  assign snap_en    = !snap_vq || snap_ready;
  assign in_ready_o = snap_en;
  assign take       = in_valid_i && in_ready_o;

  fss_accum #(
    .Window (Window)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .in_i    (in_data_i),
    .stats_o (stats)
  );

  // Hold the completed file's statistics, last byte included, for the classifier.
  always_ff @(posedge clk_i) begin
    if (take && in_data_i.last) begin
      snap_q <= stats;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vq <= 1'b0;
    end else if (snap_en) begin
      snap_vq <= take && in_data_i.last;
    end
  end

  fss_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_vq),
    .snap_ready_o (snap_ready),
    .snap_i       (snap_q),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_data_o)
  );

endmodule

[design/fss_checker.sv]
// Port-level checker for the file signature sniffer, bound to the top level.
`include "assert_macros.svh"

module fss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fss_pkg::fss_out_t out_data_o
);
  import fss_pkg::*;

  `FSS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `FSS_ASSERT(a_reject_flag, clk_i, rst_ni, out_valid_o |-> (out_data_o.rejected == (out_data_o.match_class != CLS_NONE)))
  `FSS_ASSERT(a_class_range, clk_i, rst_ni, out_valid_o |-> (out_data_o.match_class != CLS_INVALID))
  `FSS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind file_signature_sniffer fss_checker u_fss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/sv/tb_file_signature_sniffer.sv]
// Self-checking testbench for the file signature sniffer: byte streams in, verdicts checked.
module tb_file_signature_sniffer;
  import fss_pkg::*;

  // Run limits and fixed timings.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 8;    // result latency plus margin
  localparam int unsigned PERCENT       = 100;

  // Byte codes that the text rule treats specially.
  localparam logic [7:0] TAB_BYTE = 8'h09;
  localparam logic [7:0] LF_BYTE  = 8'h0A;
  localparam logic [7:0] CR_BYTE  = 8'h0D;

  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // Single-pattern signatures, in priority order; the two-part audio
  // containers are checked ahead of them and handled separately.
  localparam int unsigned MAGIC_COUNT = 21;
  localparam int unsigned MAGIC_PNG   = 3;
  localparam int unsigned MAGIC_DB    = 17;

  // Four-character tags of the two-part audio containers, first byte leftmost.
  localparam logic [127:0] TAG_RIFF = {"RIFF", 96'h0};
  localparam logic [127:0] TAG_RF64 = {"RF64", 96'h0};
  localparam logic [127:0] TAG_FORM = {"FORM", 96'h0};
  localparam logic [127:0] TAG_WAVE = {"WAVE", 96'h0};
  localparam logic [127:0] TAG_AIFF = {"AIFF", 96'h0};
  localparam logic [127:0] TAG_AIFC = {"AIFC", 96'h0};

  typedef struct packed {
    logic [4:0]       off;
    logic [4:0]       len;
    logic [CLS_W-1:0] cls;
    logic [127:0]     pat;  // first byte in the top eight bits
  } magic_t;

  // Clock, reset and block ports.
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  fss_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  fss_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Stimulus side.
  fss_in_t          pending_bytes[$];
  logic [7:0]       file_buf[$];
  logic             in_taken       = 1'b0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_idle_pct  = 0;
  int unsigned      hold_asked     = 0;
  int unsigned      hold_served    = 0;
  int unsigned      hold_left      = 0;
  int unsigned      files_queued   = 0;

  // Checking side: a private copy of the registers and of the per-file state.
  fss_out_t         expected_verdicts[$];
  int unsigned      verdicts_seen  = 0;
  int unsigned      error_count    = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      text_pct       = TEXT_PERCENT_RST;
  int unsigned      ctrl_div       = CONTROL_DIVISOR_RST;
  int unsigned      text_min       = TEXT_MIN_LENGTH_RST;
  logic [7:0]       head_bytes [HEAD_DEPTH];
  int unsigned      file_len       = 0;
  int unsigned      printable_cnt  = 0;
  int unsigned      control_cnt    = 0;
  logic             saw_break      = 1'b0;

  file_signature_sniffer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Signature table and verdict prediction
  // ---------------------------------------------------------------------------

  function automatic magic_t magic_entry(int unsigned k);
    magic_t m;
    case (k)
      0:  m = {5'd0, 5'd4,  CLS_AUDIO,   {32'h4F676753, 96'h0}};
      1:  m = {5'd0, 5'd4,  CLS_AUDIO,   {32'h664C6143, 96'h0}};
      2:  m = {5'd0, 5'd3,  CLS_AUDIO,   {24'h494433, 104'h0}};
      3:  m = {5'd0, 5'd8,  CLS_IMAGE,   {64'h89504E470D0A1A0A, 64'h0}};
      4:  m = {5'd0, 5'd3,  CLS_IMAGE,   {24'hFFD8FF, 104'h0}};
      5:  m = {5'd0, 5'd6,  CLS_IMAGE,   {48'h474946383761, 80'h0}};
      6:  m = {5'd0, 5'd6,  CLS_IMAGE,   {48'h474946383961, 80'h0}};
      7:  m = {5'd0, 5'd2,  CLS_IMAGE,   {16'h424D, 112'h0}};
      8:  m = {5'd0, 5'd4,  CLS_ARCHIVE, {32'h504B0304, 96'h0}};
      9:  m = {5'd0, 5'd4,  CLS_ARCHIVE, {32'h504B0506, 96'h0}};
      10: m = {5'd0, 5'd6,  CLS_ARCHIVE, {48'h377ABCAF271C, 80'h0}};
      11: m = {5'd0, 5'd6,  CLS_ARCHIVE, {48'h526172211A07, 80'h0}};
      12: m = {5'd0, 5'd2,  CLS_ARCHIVE, {16'h1F8B, 112'h0}};
      13: m = {5'd0, 5'd3,  CLS_ARCHIVE, {24'h425A68, 104'h0}};
      14: m = {5'd0, 5'd6,  CLS_ARCHIVE, {48'hFD377A585A00, 80'h0}};
      15: m = {5'd0, 5'd5,  CLS_DOC,     {40'h255044462D, 88'h0}};
      16: m = {5'd0, 5'd4,  CLS_DOC,     {32'h7F454C46, 96'h0}};
      // full sixteen-byte database header, trailing zero included
      17: m = {5'd0, 5'd16, CLS_DOC,     128'h53514C69746520666F726D6174203300};
      18: m = {5'd0, 5'd2,  CLS_DOC,     {16'h4D5A, 112'h0}};
      19: m = {5'd4, 5'd4,  CLS_VIDEO,   {32'h66747970, 96'h0}};
      20: m = {5'd0, 5'd4,  CLS_VIDEO,   {32'h1A45DFA3, 96'h0}};
      default: m = '0;
    endcase
    return m;
  endfunction

  // A pattern only counts where every byte it covers was seen in this file.
  function automatic logic head_holds(int unsigned off, int unsigned n, logic [127:0] pat);
    if (off + n > HEAD_DEPTH || off + n > file_len) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (head_bytes[off + i] != pat[127 - 8 * i -: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [CLS_W-1:0] expected_class();
    magic_t m;
    if (file_len < SHORT_LEN) return CLS_NONE;
    if ((head_holds(0, 4, TAG_RIFF) || head_holds(0, 4, TAG_RF64)) &&
        head_holds(8, 4, TAG_WAVE)) return CLS_AUDIO;
    if (head_holds(0, 4, TAG_FORM) &&
        (head_holds(8, 4, TAG_AIFF) || head_holds(8, 4, TAG_AIFC))) return CLS_AUDIO;
    for (int unsigned k = 0; k < MAGIC_COUNT; k++) begin
      m = magic_entry(k);
      if (head_holds(m.off, m.len, m.pat)) return m.cls;
    end
    // Text: ratios in multiply-compare form, so no rounding enters.
    if (file_len >= text_min &&
        printable_cnt * PERCENT >= text_pct * file_len &&
        (control_cnt + 1) * ctrl_div <= file_len &&
        saw_break) return CLS_TEXT;
    return CLS_NONE;
  endfunction

  // Fold one accepted byte into the file statistics; on the last byte queue the verdict.
  task automatic absorb_byte(fss_in_t item);
    logic [7:0] c;
    fss_out_t   v;
    c = item.data_byte;
    if (file_len < WINDOW) begin
      if (file_len < HEAD_DEPTH) head_bytes[file_len] = c;
      if (c == CR_BYTE || c == LF_BYTE || c == TAB_BYTE || (c >= 8'h20 && c <= 8'h7E))
        printable_cnt++;
      else if (c != 8'h00)
        control_cnt++;
      if (c == CR_BYTE || c == LF_BYTE) saw_break = 1'b1;
      file_len++;
    end
    if (item.last) begin
      v.match_class = expected_class();
      v.rejected    = (v.match_class != CLS_NONE);
      expected_verdicts.push_back(v);
      file_len      = 0;
      printable_cnt = 0;
      control_cnt   = 0;
      saw_break     = 1'b0;
    end
  endtask

  task automatic flag_mismatch(string what);
    $display("[%0d] mismatch: %s", cycle_count, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes, input transfers and result transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fss_out_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_file_signature_sniffer: errors");
      $finish;
    end
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      // Check the result side first; a verdict can never leave in the cycle its
      // last byte arrives, but keep the order independent of that anyway.
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          flag_mismatch($sformatf("verdict %0b/%0d with none outstanding",
                                  out_data.rejected, out_data.match_class));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.rejected !== want.rejected)
            flag_mismatch($sformatf("rejected %0b, wanted %0b",
                                    out_data.rejected, want.rejected));
          if (out_data.match_class !== want.match_class)
            flag_mismatch($sformatf("match_class %0d, wanted %0d",
                                    out_data.match_class, want.match_class));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TEXT_PERCENT:    text_pct = cfg_wdata[PCT_W-1:0];
          CFG_CONTROL_DIVISOR: ctrl_div = cfg_wdata[DIV_W-1:0];
          CFG_TEXT_MIN_LENGTH: text_min = cfg_wdata;
          default: ;  // spare index: the block must ignore it
        endcase
      end
      if (in_valid && in_ready) absorb_byte(in_data);
      in_taken <= in_valid && in_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued bytes, holding each one until its transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request, counted here.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // File builders
  // ---------------------------------------------------------------------------

  task automatic new_buf(int unsigned len);
    file_buf.delete();
    repeat (len) file_buf.push_back(8'($urandom_range(255, 0)));
  endtask

  task automatic flat_buf(int unsigned len, logic [7:0] value);
    file_buf.delete();
    repeat (len) file_buf.push_back(value);
  endtask

  // Write pattern bytes into the buffer; drop whatever falls past its end.
  task automatic place(int unsigned off, int unsigned n, logic [127:0] pat);
    for (int unsigned i = 0; i < n; i++) begin
      if (off + i < file_buf.size()) file_buf[off + i] = pat[127 - 8 * i -: 8];
    end
  endtask

  // Indexes past the table stand for the four two-part audio containers.
  task automatic stamp_magic(int unsigned k);
    magic_t m;
    case (k)
      MAGIC_COUNT:     begin place(0, 4, TAG_RIFF); place(8, 4, TAG_WAVE); end
      MAGIC_COUNT + 1: begin place(0, 4, TAG_RF64); place(8, 4, TAG_WAVE); end
      MAGIC_COUNT + 2: begin place(0, 4, TAG_FORM); place(8, 4, TAG_AIFF); end
      MAGIC_COUNT + 3: begin place(0, 4, TAG_FORM); place(8, 4, TAG_AIFC); end
      default: begin
        m = magic_entry(k);
        place(m.off, m.len, m.pat);
      end
    endcase
  endtask

  // Mostly printable bytes; ctrl_pct sets the share of control bytes.
  task automatic build_text(int unsigned len, int unsigned ctrl_pct, logic with_break);
    int unsigned r;
    logic [7:0]  c;
    file_buf.delete();
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(99, 0);
      if (r < ctrl_pct) begin
        c = $urandom_range(1, 0) ? 8'($urandom_range(255, 127)) : 8'($urandom_range(31, 1));
        if (c == TAB_BYTE || c == LF_BYTE || c == CR_BYTE) c = 8'h7F;
      end else if (r < ctrl_pct + 1) begin
        c = 8'h00;
      end else if (r < ctrl_pct + 6) begin
        if (!with_break) c = TAB_BYTE;
        else c = $urandom_range(1, 0) ? LF_BYTE : CR_BYTE;
      end else begin
        c = 8'($urandom_range(126, 32));
      end
      file_buf.push_back(c);
    end
    if (with_break && len > 0) file_buf[len / 2] = LF_BYTE;
  endtask

  // Turn the buffer into transfers, marking the final byte.
  task automatic send_file();
    fss_in_t b;
    foreach (file_buf[i]) begin
      b.data_byte = file_buf[i];
      b.last      = (i == file_buf.size() - 1);
      pending_bytes.push_back(b);
    end
    files_queued++;
  endtask

  // One random file, weighted towards well-formed signatures and text.
  task automatic queue_random_file(int unsigned hint, output int unsigned n);
    int unsigned pick, ctrl;
    int          len;
    pick = $urandom_range(99, 0);
    if (pick < 30) begin
      new_buf(($urandom_range(9, 0) == 0) ? $urandom_range(64, 17) : $urandom_range(24, 12));
      stamp_magic($urandom_range(MAGIC_COUNT + 3, 0));
    end else if (pick < 42) begin
      if ($urandom_range(1, 0)) begin
        // dent one header byte
        new_buf($urandom_range(24, 12));
        stamp_magic($urandom_range(MAGIC_COUNT + 3, 0));
        file_buf[$urandom_range(11, 0)] ^= 8'(1 << $urandom_range(7, 0));
      end else begin
        // cut the file off inside or just past the signature
        new_buf($urandom_range(15, 1));
        stamp_magic($urandom_range(MAGIC_COUNT + 3, 0));
      end
    end else if (pick < 72) begin
      len = int'(hint) + int'($urandom_range(20, 0)) - 10;
      if (len < 1) len = 1;
      case ($urandom_range(3, 0))
        0:       ctrl = 0;
        1:       ctrl = 1;
        2:       ctrl = 4;
        default: ctrl = 15;
      endcase
      build_text(len, ctrl, $urandom_range(9, 0) != 0);
    end else if (pick < 84) begin
      new_buf($urandom_range(11, 1));
      if ($urandom_range(1, 0)) stamp_magic($urandom_range(MAGIC_COUNT + 3, 0));
    end else begin
      new_buf($urandom_range(40, 1));
    end
    n = file_buf.size();
    send_file();
  endtask

  task automatic queue_random_bytes(int unsigned target, int unsigned hint);
    int unsigned done, n;
    done = 0;
    while (done < target) begin
      queue_random_file(hint, n);
      done += n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Advance until every queued file has had its verdict.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (verdicts_seen != files_queued || expected_verdicts.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drain, let the pipeline settle, then load all three registers.
  task automatic load_settings(logic [CFG_W-1:0] pct, logic [CFG_W-1:0] div,
                               logic [CFG_W-1:0] min_len);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_TEXT_PERCENT, pct);
    write_reg(CFG_CONTROL_DIVISOR, div);
    write_reg(CFG_TEXT_MIN_LENGTH, min_len);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings (94/50/256); sender idles lightly, receiver heavily.
    send_idle_pct = 20;
    recv_idle_pct = 51;

    // Every signature once, in a file just long enough for the header to be classified.
    for (int unsigned k = 0; k < MAGIC_COUNT + 4; k++) begin
      new_buf((k == MAGIC_DB) ? 16 : 12);
      stamp_magic(k);
      send_file();
    end
    flat_buf(12, 8'hFF);
    send_file();
    // a one-byte file, and a short file whose prefix matches an image header
    new_buf(1);
    send_file();
    new_buf(11);
    stamp_magic(MAGIC_PNG);
    send_file();
    // database header cut short: the sixteen-byte pattern must not match
    new_buf(13);
    stamp_magic(MAGIC_DB);
    send_file();

    // Zero percentage, zero divisor, no minimum; poke the spare index too.
    load_settings(13'd0, 13'd0, 13'd0);
    write_reg(CFG_SPARE_IDX, 13'($urandom_range(8191, 0)));
    // Stall the result side for a long stretch while files keep streaming in,
    // so the pipeline fills and the input has to back off.
    hold_asked++;
    for (int unsigned i = 0; i < 6; i++) begin
      int unsigned n;
      queue_random_file(14, n);
    end

    // Strictest percentage, widest divisor; roles of the two sides swapped.
    load_settings(13'd100, 13'd255, 13'd12);
    send_idle_pct = 51;
    recv_idle_pct = 20;
    queue_random_bytes(15, 14);
    // hold the sender back until every verdict so far is in
    wait_for_drain();
    queue_random_bytes(15, 14);

    // Percentage above 100: text can never pass.
    load_settings(13'd127, 13'd1, 13'd20);
    queue_random_bytes(15, 22);

    // Text at and just below the minimum length; neither side idles from here.
    load_settings(13'd90, 13'd10, 13'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    build_text(16, 0, 1'b1);
    send_file();
    build_text(15, 0, 1'b1);
    send_file();

    // Minimum beyond the window: text never passes.
    load_settings(13'd90, 13'd10, 13'd8191);
    build_text(20, 0, 1'b1);
    send_file();

    // Random settings, upper bits of the narrow registers included.
    load_settings(13'($urandom_range(8191, 0)), 13'($urandom_range(8191, 0)),
                  $urandom_range(1, 0) ? 13'($urandom_range(48, 0))
                                       : 13'($urandom_range(8191, 0)));
    queue_random_bytes(15, 30);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_file_signature_sniffer: clean");
    end else begin
      $display("tb_file_signature_sniffer: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/fss_pkg.sv
design/fss_accum.sv
design/fss_classify.sv
design/file_signature_sniffer.sv
design/fss_checker.sv
tb/sv/tb_file_signature_sniffer.sv
